@@ rtl/core/sensor_sample_smoothing_filters_top_assert.svh @@
// ---------------------------------------------------------------------------
// Sensor smoothing filters assertion macros
// Clocked property shorthands; expect clk and rst_n in the using scope.
// ---------------------------------------------------------------------------
`ifndef SENSOR_SAMPLE_SMOOTHING_FILTERS_TOP_ASSERT_SVH
`define SENSOR_SAMPLE_SMOOTHING_FILTERS_TOP_ASSERT_SVH

// same-cycle implication
`define SSSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sssf_pkg.sv @@
// ---------------------------------------------------------------------------
// Sensor smoothing filters package
// Shared types, reset levels and register indexes.
// ---------------------------------------------------------------------------
`default_nettype none

package sssf_pkg;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned FIR_LEN = 6;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic signed [15:0] RESET_LEVEL = 16'sd16000;
  localparam logic signed [31:0] IIR_RESET   = 32'sd524288000;

  localparam logic signed [15:0] FIR_OUTER_RST  = 16'sd865;
  localparam logic signed [15:0] FIR_MIDDLE_RST = 16'sd4604;
  localparam logic signed [15:0] FIR_INNER_RST  = 16'sd10915;
  localparam logic [14:0]        IIR_KEEP_RST   = 15'd26214;
  localparam logic [14:0]        IIR_WEIGHT_RST = 15'd6554;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIR_OUTER  = 3'd0,
    REG_FIR_MIDDLE = 3'd1,
    REG_FIR_INNER  = 3'd2,
    REG_IIR_KEEP   = 3'd3,
    REG_IIR_WEIGHT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] fir_outer;
    logic signed [15:0] fir_middle;
    logic signed [15:0] fir_inner;
    logic [14:0]        iir_keep;
    logic [14:0]        iir_weight;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic load;
  } ctl_t;

  typedef logic [FIR_LEN-1:0][DATA_W-1:0] dly_t;

endpackage

`default_nettype wire

@@ rtl/core/sssf_state.sv @@
// ---------------------------------------------------------------------------
// Sensor smoothing filters state stage
// Window shift line and running sum, FIR delay line and IIR recurrence.
// ---------------------------------------------------------------------------
`default_nettype none

module sssf_state
  import sssf_pkg::*;
#(
  parameter int unsigned MAF_TAPS = 8
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire ctl_t                                    ctl,
  input  wire cfg_t                                    cfg,
  input  wire logic signed [15:0]                      sample,
  output logic signed [16+$clog2(MAF_TAPS)-1:0]        sum_r,
  output dly_t                                         dly_r,
  output logic signed [31:0]                           iir_r
);

  localparam int unsigned SW = 16 + $clog2(MAF_TAPS);
  localparam logic signed [SW-1:0] SUM_RST = SW'(MAF_TAPS * 16000);

  logic signed [15:0]   win_r [MAF_TAPS];
  logic signed [SW-1:0] sum_nxt;
  logic signed [47:0]   keep_prod;
  logic signed [32:0]   keep_part;
  logic signed [31:0]   new_part;
  logic signed [33:0]   iir_sum;
  logic signed [31:0]   iir_nxt;

  assign sum_nxt = sum_r - SW'(win_r[MAF_TAPS-1]) + SW'(sample);

  assign keep_prod = 48'($signed({1'b0, cfg.iir_keep})) * 48'(iir_r);
  assign keep_part = keep_prod[47:15];
  assign new_part  = 32'($signed({1'b0, cfg.iir_weight})) * 32'(sample);
  assign iir_sum   = 34'(keep_part) + 34'(new_part);

  always_comb begin
    if (iir_sum > 34'sh0_7FFF_FFFF) begin
      iir_nxt = 32'sh7FFF_FFFF;
    end else if (iir_sum < -34'sh0_8000_0000) begin
      iir_nxt = 32'sh8000_0000;
    end else begin
      iir_nxt = iir_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAF_TAPS; k++) begin
        win_r[k] <= RESET_LEVEL;
      end
      sum_r <= SUM_RST;
      for (int k = 0; k < FIR_LEN; k++) begin
        dly_r[k] <= RESET_LEVEL;
      end
      iir_r <= IIR_RESET;
    end else if (ctl.take) begin
      win_r[0] <= sample;
      for (int k = 1; k < MAF_TAPS; k++) begin
        win_r[k] <= win_r[k-1];
      end
      sum_r <= sum_nxt;
      dly_r[0] <= sample;
      for (int k = 1; k < FIR_LEN; k++) begin
        dly_r[k] <= dly_r[k-1];
      end
      iir_r <= iir_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sssf_calc.sv @@
// ---------------------------------------------------------------------------
// Sensor smoothing filters result stage
// Average, IIR integer part and FIR sum from the state, into the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module sssf_calc
  import sssf_pkg::*;
#(
  parameter int unsigned MAF_TAPS = 8
) (
  input  wire logic                                    clk,
  input  wire ctl_t                                    ctl,
  input  wire cfg_t                                    cfg,
  input  wire logic signed [16+$clog2(MAF_TAPS)-1:0]   sum_r,
  input  wire dly_t                                    dly_r,
  input  wire logic signed [31:0]                      iir_r,
  output logic signed [15:0]                           avg_r,
  output logic signed [15:0]                           iir_out_r,
  output logic signed [15:0]                           fir_out_r
);

  localparam int unsigned L  = $clog2(MAF_TAPS);
  localparam int unsigned SW = 16 + L;
  localparam int unsigned S  = SW + L;
  localparam logic [S:0] RECIP = (S+1)'(((64'd1 << S) + MAF_TAPS - 1) / MAF_TAPS);

  logic [SW-1:0]      mag;
  logic [SW+S:0]      quo_prod;
  logic [15:0]        quo;
  logic signed [15:0] avg_nxt;

  logic signed [16:0] iir_fl;
  logic               iir_up;
  logic signed [17:0] iir_tz;
  logic signed [15:0] iir_nxt;

  logic signed [16:0] pair_o;
  logic signed [16:0] pair_m;
  logic signed [16:0] pair_i;
  logic signed [32:0] prod_o;
  logic signed [32:0] prod_m;
  logic signed [32:0] prod_i;
  logic signed [34:0] fir_acc;
  logic signed [19:0] fir_sh;
  logic signed [15:0] fir_nxt;

  // truncate toward zero through a reciprocal multiply on the magnitude
  assign mag      = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
  assign quo_prod = (SW+S+1)'(mag) * (SW+S+1)'(RECIP);
  assign quo      = quo_prod[S +: 16];
  assign avg_nxt  = sum_r[SW-1] ? 16'(-quo) : quo;

  assign iir_fl = iir_r[31:15];
  assign iir_up = iir_r[31] && (|iir_r[14:0]);
  assign iir_tz = {iir_fl[16], iir_fl} + {17'd0, iir_up};

  always_comb begin
    if (iir_tz > 18'sd32767) begin
      iir_nxt = 16'sh7FFF;
    end else if (iir_tz < -18'sd32768) begin
      iir_nxt = 16'sh8000;
    end else begin
      iir_nxt = iir_tz[15:0];
    end
  end

  assign pair_o = 17'($signed(dly_r[0])) + 17'($signed(dly_r[5]));
  assign pair_m = 17'($signed(dly_r[1])) + 17'($signed(dly_r[4]));
  assign pair_i = 17'($signed(dly_r[2])) + 17'($signed(dly_r[3]));
  assign prod_o = 33'(cfg.fir_outer) * 33'(pair_o);
  assign prod_m = 33'(cfg.fir_middle) * 33'(pair_m);
  assign prod_i = 33'(cfg.fir_inner) * 33'(pair_i);
  assign fir_acc = 35'(prod_o) + 35'(prod_m) + 35'(prod_i);
  assign fir_sh  = fir_acc[34:15];

  always_comb begin
    if (fir_sh > 20'sd32767) begin
      fir_nxt = 16'sh7FFF;
    end else if (fir_sh < -20'sd32768) begin
      fir_nxt = 16'sh8000;
    end else begin
      fir_nxt = fir_sh[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      avg_r     <= avg_nxt;
      iir_out_r <= iir_nxt;
      fir_out_r <= fir_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sensor_sample_smoothing_filters_top.sv @@
// ---------------------------------------------------------------------------
// Sensor sample smoothing filters
// Moving average, first-order IIR and symmetric 6-tap FIR over one sample stream.
//
//   channel   direction  handshake          payload
//   in        input      in_valid/in_stall  in_sample
//   out       output     out_valid/out_stall out_average_out, out_iir_out, out_fir_out
//   cfg       input      cfg_we             cfg_idx, cfg_wdata
//
// One sample per cycle while in_stall is low; results come from the result register.
// The state stage updates on accept, the result register when empty or not stalled.
// Synchronous active-low reset restores filter state and register defaults.
// out_stall holds the result register; in_stall rises only while both stages are full.
// ---------------------------------------------------------------------------
`default_nettype none

module sensor_sample_smoothing_filters_top
  import sssf_pkg::*;
#(
  parameter int unsigned MAF_TAPS = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [15:0]      in_sample,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [15:0]           out_average_out,
  output logic signed [15:0]           out_iir_out,
  output logic signed [15:0]           out_fir_out,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [15:0]             cfg_wdata
);

`include "sensor_sample_smoothing_filters_top_assert.svh"

  localparam int unsigned SW = 16 + $clog2(MAF_TAPS);

  cfg_t               cfg_r;
  ctl_t               ctl;
  logic               pend_r;
  logic               pend_nxt;
  logic               out_vld_r;
  logic               out_vld_nxt;
  logic signed [SW-1:0] sum_r;
  dly_t               dly_r;
  logic signed [31:0] iir_r;

  assign ctl.load  = pend_r && (!out_vld_r || !out_stall);
  assign in_stall  = pend_r && !ctl.load;
  assign ctl.take  = in_valid && !in_stall;
  assign pend_nxt    = ctl.take || (pend_r && !ctl.load);
  assign out_vld_nxt = ctl.load || (out_vld_r && out_stall);
  assign out_valid = out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      pend_r    <= pend_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fir_outer  <= FIR_OUTER_RST;
      cfg_r.fir_middle <= FIR_MIDDLE_RST;
      cfg_r.fir_inner  <= FIR_INNER_RST;
      cfg_r.iir_keep   <= IIR_KEEP_RST;
      cfg_r.iir_weight <= IIR_WEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_FIR_OUTER:  cfg_r.fir_outer  <= cfg_wdata;
        REG_FIR_MIDDLE: cfg_r.fir_middle <= cfg_wdata;
        REG_FIR_INNER:  cfg_r.fir_inner  <= cfg_wdata;
        REG_IIR_KEEP:   cfg_r.iir_keep   <= cfg_wdata[14:0];
        REG_IIR_WEIGHT: cfg_r.iir_weight <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  sssf_state #(
    .MAF_TAPS(MAF_TAPS)
  ) u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .cfg    (cfg_r),
    .sample (in_sample),
    .sum_r  (sum_r),
    .dly_r  (dly_r),
    .iir_r  (iir_r)
  );

  sssf_calc #(
    .MAF_TAPS(MAF_TAPS)
  ) u_calc (
    .clk       (clk),
    .ctl       (ctl),
    .cfg       (cfg_r),
    .sum_r     (sum_r),
    .dly_r     (dly_r),
    .iir_r     (iir_r),
    .avg_r     (out_average_out),
    .iir_out_r (out_iir_out),
    .fir_out_r (out_fir_out)
  );

  `SSSF_ASSERT_NEXT(a_take_fills_pend, ctl.take, pend_r, "accepted item not held in state stage")
  `SSSF_ASSERT_NEXT(a_load_fills_out, ctl.load, out_vld_r, "loaded item not presented")
  `SSSF_ASSERT_NEXT(a_pend_kept, pend_r && !ctl.load, pend_r, "pending item dropped")
  `SSSF_ASSERT_NOW(a_stall_only_full, in_stall, pend_r && out_vld_r && out_stall, "stall while space free")

endmodule

`default_nettype wire
